// File: rtl/core/egps_pkg.sv
// egps_pkg: shared constants, command codes and controller/datapath structs
// for the envelope gain block. No dependencies.
`default_nettype none
package egps_pkg;
  localparam int MAX_POINTS = 16;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [30:0] LAST_INDEX = 31'h7fffffff;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic CFG_GAIN_MODE = 1'b0;
  localparam logic CFG_CONST_GAIN = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] sample_in;
    logic [30:0] point_time;
    logic [23:0] point_gain;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] scaled_sample;
    logic [22:0] peak_max;
    logic [30:0] max_position;
    logic [30:0] max_count;
    logic [23:0] peak_min;
    logic [30:0] min_position;
    logic [30:0] min_count;
  } out_beat_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch input beat
    logic clear;      // restart state
    logic load_start; // start slope divisions
    logic load_commit;
    logic seek;       // one segment search step
    logic gain_calc;  // envelope multiply
    logic scale;      // sample multiply
    logic finish;     // saturate, stats, result
    logic report;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic seek_done;
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// File: rtl/core/egps_if.sv
// egps_stream_if: valid/ready channel carrying one payload of type T.
// Uses egps_pkg types at instantiation.
`default_nettype none
interface egps_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/egps_div.sv
// egps_div: restoring divider, one quotient bit per cycle, signed result
// truncated toward zero. Depends on nothing outside this file.
`default_nettype none
module egps_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [48:0] num,    // signed numerator
  input  wire logic [30:0] den,    // unsigned, nonzero
  output logic             busy,
  output logic [48:0]      quo     // signed quotient
);
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] den_r, den_nxt;
  logic        busy_r, busy_nxt;
  logic [48:0] mag;
  logic [48:0] trial;

  assign mag = num[48] ? -num : num;
  assign trial = {rem_r, q_r[47]} - {18'd0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    den_nxt = den_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0;
      q_nxt = mag[47:0];
      cnt_nxt = 6'd48;
      neg_nxt = num[48];
      den_nxt = den;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[48]) begin
        rem_nxt = trial[47:0];
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[46:0], q_r[47]};
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
endmodule
`default_nettype wire

// File: rtl/core/egps_dp.sv
// egps_dp: envelope store, slope dividers, multipliers and peak statistics.
// Depends on egps_pkg and egps_div.
`default_nettype none
module egps_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire egps_pkg::in_beat_t   in_beat,
  input  wire egps_pkg::dp_cmd_t    cmd,
  input  wire logic                 gain_mode,
  input  wire logic signed [23:0]   constant_gain,
  output egps_pkg::dp_sts_t         sts,
  output egps_pkg::out_beat_t       result
);
  localparam int PW = egps_pkg::PW;
  localparam int CW = egps_pkg::CW;

  logic [30:0]        pt_idx [egps_pkg::MAX_POINTS];
  logic signed [23:0] pt_gain [egps_pkg::MAX_POINTS];
  logic signed [47:0] pt_slope [egps_pkg::MAX_POINTS];

  egps_pkg::in_beat_t in_r;
  logic [30:0] cnt_r;
  logic [CW-1:0] seg_r, pcount_r;
  logic signed [47:0] tail_r;
  logic signed [23:0] maxv_r, minv_r;
  logic [30:0] maxat_r, maxt_r, minat_r, mint_r;
  logic signed [23:0] gain_r;
  logic signed [39:0] prod_r;
  logic [30:0] ld_t_r;
  logic [30:0] ld_t0_r;
  egps_pkg::out_beat_t res_r;
  logic signed [23:0] env_g0_r;
  logic signed [47:0] env_sl_r;
  logic [30:0] env_d_r;
  logic [54:0] env_lo_r;
  logic signed [55:0] env_hi_r;

  // segment view helpers
  logic [PW-1:0] seg_m1, seg_lo;
  logic [30:0] s_start, s_end;
  logic signed [23:0] s_g0;
  logic signed [47:0] s_slope;
  assign seg_m1 = PW'(seg_r - CW'(1));
  assign seg_lo = seg_r[PW-1:0];
  assign s_start = (seg_r == '0) ? 31'd0 : pt_idx[seg_m1];
  assign s_g0 = (seg_r == '0) ? 24'sd0 : pt_gain[seg_m1];
  assign s_end = (seg_r < pcount_r) ? pt_idx[seg_lo] : egps_pkg::LAST_INDEX;
  assign s_slope = (seg_r < pcount_r) ? pt_slope[seg_lo] : tail_r;

  logic restart_seek;
  logic seek_done, div_done;
  assign restart_seek = (seg_r > pcount_r) || (cnt_r < s_start);
  assign seek_done = !restart_seek && !((seg_r < pcount_r) && (cnt_r > s_end));

  // load point: clamp index, two divisions
  logic full;
  logic [30:0] ld_t0, ld_t;
  logic signed [23:0] ld_g0;
  assign full = (pcount_r == CW'(egps_pkg::MAX_POINTS));
  assign ld_t0 = (pcount_r == '0) ? 31'd0 : pt_idx[PW'(pcount_r - CW'(1))];
  assign ld_g0 = (pcount_r == '0) ? 24'sd0 : pt_gain[PW'(pcount_r - CW'(1))];
  assign ld_t = (in_r.point_time < ld_t0) ? ld_t0 : in_r.point_time;

  logic b1, b2;
  logic [48:0] q1, q2;
  logic signed [24:0] dg1, dg2;
  assign dg1 = 25'($signed(in_r.point_gain)) - 25'(ld_g0);
  assign dg2 = -25'($signed(in_r.point_gain));
  egps_div u_div_seg (.clk, .rst_n, .start(cmd.load_start),
    .num({dg1, 24'd0}), .den(ld_t - ld_t0), .busy(b1), .quo(q1));
  egps_div u_div_tail (.clk, .rst_n, .start(cmd.load_start),
    .num({dg2, 24'd0}), .den(egps_pkg::LAST_INDEX - ld_t), .busy(b2), .quo(q2));
  assign div_done = !b1 && !b2;
  assign sts = '{seek_done: seek_done, div_done: div_done};

  function automatic logic signed [47:0] sat48(input logic [48:0] q);
    if (q[48] != q[47]) sat48 = q[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat48 = q[47:0];
  endfunction

  // envelope gain assembly: slope split in a signed upper and unsigned lower half
  logic signed [56:0] env_sum;
  logic signed [23:0] env_gain;
  assign env_sum = 57'(env_g0_r) + 57'(env_hi_r) + $signed({26'd0, env_lo_r[54:24]});
  assign env_gain = (env_sum > 57'sd8388607) ? 24'sd8388607 :
                    (env_sum < -57'sd8388608) ? -24'sd8388608 : env_sum[23:0];

  logic signed [40:0] rnd;
  logic signed [24:0] v25;
  logic signed [23:0] v;
  assign rnd = 41'(prod_r) + 41'sd32768;
  assign v25 = (rnd >>> 16) > 41'sd8388607 ? 25'sd8388607 :
               (rnd >>> 16) < -41'sd8388608 ? -25'sd8388608 : 25'(rnd >>> 16);
  assign v = v25[23:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_beat;
    if (cmd.load_start) begin
      ld_t_r <= ld_t;
      ld_t0_r <= ld_t0;
    end
    if (cmd.load_commit && !full) begin
      pt_idx[pcount_r[PW-1:0]] <= ld_t_r;
      pt_gain[pcount_r[PW-1:0]] <= in_r.point_gain;
      pt_slope[pcount_r[PW-1:0]] <= (ld_t_r <= ld_t0_r) ? 48'sd0 : sat48(q1);
    end
    if (cmd.gain_calc) begin
      env_g0_r <= s_g0;
      env_sl_r <= s_slope;
      env_d_r <= cnt_r - s_start;
    end
    env_lo_r <= env_sl_r[23:0] * env_d_r;
    env_hi_r <= $signed(env_sl_r[47:24]) * $signed({1'b0, env_d_r});
    if (cmd.scale) begin
      gain_r <= gain_mode ? env_gain : constant_gain;
    end
    prod_r <= $signed(in_r.sample_in) * gain_r;
    if (cmd.finish) begin
      res_r <= '{kind: 1'b0, scaled_sample: v, peak_max: 23'd0,
                 max_position: 31'd0, max_count: 31'd0, peak_min: 24'd0,
                 min_position: 31'd0, min_count: 31'd0};
    end
    if (cmd.report) begin
      res_r <= '{kind: 1'b1, scaled_sample: 24'd0, peak_max: maxv_r[22:0],
                 max_position: maxat_r, max_count: maxt_r, peak_min: minv_r,
                 min_position: minat_r, min_count: mint_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r <= '0; seg_r <= '0; pcount_r <= '0; tail_r <= '0;
      maxv_r <= '0; maxat_r <= '0; maxt_r <= '0;
      minv_r <= '0; minat_r <= '0; mint_r <= '0;
    end else begin
      if (cmd.load_commit && !full) begin
        pcount_r <= pcount_r + CW'(1);
        tail_r <= (egps_pkg::LAST_INDEX <= ld_t_r) ? 48'sd0 : sat48(q2);
      end
      if (cmd.seek) begin
        if (restart_seek) seg_r <= '0;
        else if (!seek_done) seg_r <= seg_r + CW'(1);
      end
      if (cmd.finish) begin
        if (v > maxv_r) begin
          maxv_r <= v; maxat_r <= cnt_r; maxt_r <= 31'd1;
        end else if (v == maxv_r && maxt_r != egps_pkg::LAST_INDEX)
          maxt_r <= maxt_r + 31'd1;
        if (v < minv_r) begin
          minv_r <= v; minat_r <= cnt_r; mint_r <= 31'd1;
        end else if (v == minv_r && mint_r != egps_pkg::LAST_INDEX)
          mint_r <= mint_r + 31'd1;
        if (cnt_r != egps_pkg::LAST_INDEX) cnt_r <= cnt_r + 31'd1;
      end
    end
  end

  assign result = res_r;

`ifndef ASSERT_OFF
  a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= CW'(egps_pkg::MAX_POINTS)) else $error("point count overflow");
  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gain_calc |-> seg_r <= pcount_r) else $error("segment past end");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !cmd.clear && cnt_r != egps_pkg::LAST_INDEX
    |=> cnt_r == $past(cnt_r) + 31'd1)
    else $error("sample counter step");
`endif
endmodule
`default_nettype wire

// File: rtl/core/egps_ctrl.sv
// egps_ctrl: command sequencer and output register handshake.
// Depends on egps_pkg.
`default_nettype none
module egps_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_cmd,
  input  wire logic                gain_mode,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire egps_pkg::dp_sts_t   sts,
  output egps_pkg::dp_cmd_t        cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_LDIV = 4'd2,
    S_LWAIT = 4'd3, S_SEEK = 4'd4, S_EGAIN = 4'd5, S_EMUL = 4'd6,
    S_EMUL2 = 4'd7, S_SCALE = 4'd8, S_MUL = 4'd9, S_FIN = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [1:0] c_r;
  logic ov_r, ov_nxt;

  // a result waits in the output register; a new beat only needs it free at the end
  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    ov_nxt = ov_r && !out_ready;
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.capture = 1'b1;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        case (c_r)
          egps_pkg::CMD_LOAD: begin cmd.load_start = 1'b1; st_nxt = S_LDIV; end
          egps_pkg::CMD_CLEAR: begin cmd.clear = 1'b1; st_nxt = S_IDLE; end
          egps_pkg::CMD_REPORT: if (!ov_nxt) begin
            cmd.report = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
          end
          default: st_nxt = gain_mode ? S_SEEK : S_SCALE;
        endcase
      end
      S_LDIV: st_nxt = S_LWAIT;
      S_LWAIT: if (sts.div_done) begin cmd.load_commit = 1'b1; st_nxt = S_IDLE; end
      S_SEEK: begin
        cmd.seek = 1'b1;
        if (sts.seek_done) st_nxt = S_EGAIN;
      end
      S_EGAIN: begin cmd.gain_calc = 1'b1; st_nxt = S_EMUL; end
      S_EMUL: st_nxt = S_EMUL2;
      S_EMUL2: st_nxt = S_SCALE;
      S_SCALE: begin cmd.scale = 1'b1; st_nxt = S_MUL; end
      S_MUL: st_nxt = S_FIN;
      S_FIN: if (!ov_nxt) begin
        cmd.finish = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    if (cmd.capture) c_r <= in_cmd;
  end

  assign out_valid = ov_r;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish || cmd.report) |=> ov_r) else $error("result not shown");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.finish, cmd.report, cmd.load_commit, cmd.clear}))
    else $error("overlapping commands");
`endif
endmodule
`default_nettype wire

// File: rtl/core/envelope_gain_with_peak_stats.sv
// Envelope gain with peak statistics: scales samples by a constant or a
// piecewise-linear gain and keeps max/min statistics. Loading a breakpoint
// waits for the 48-step slope divider. A sample with constant gain goes
// through the sample multiply; with the envelope it first passes the
// segment search, one segment per step and restarting from the first
// segment when needed, and the envelope multiply pipeline.
// The output register holds a result until taken while the next beat enters.
`default_nettype none
module envelope_gain_with_peak_stats (
  input  wire logic clk,
  input  wire logic rst_n,
  egps_stream_if.sink   in_ch,
  egps_stream_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  logic gain_mode_r;
  logic signed [23:0] cgain_r;
  egps_pkg::dp_cmd_t cmd;
  egps_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_mode_r <= 1'b0;
      cgain_r <= 24'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        egps_pkg::CFG_GAIN_MODE: gain_mode_r <= cfg_wdata[0];
        egps_pkg::CFG_CONST_GAIN: cgain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  egps_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.data.cmd), .gain_mode(gain_mode_r), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .sts, .cmd);

  egps_dp u_dp (.clk, .rst_n, .in_beat(in_ch.data), .cmd,
    .gain_mode(gain_mode_r), .constant_gain(cgain_r), .sts, .result(out_ch.data));
endmodule
`default_nettype wire

// File: verif/egps_checker.sv
// egps_checker: watches the input, result and register ports of the envelope
// gain block, predicts every result and compares it. Depends on egps_pkg.
`timescale 1ns / 1ps
module egps_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire egps_pkg::in_beat_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire egps_pkg::out_beat_t out_data,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [23:0]         cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       results_seen
);
  logic               mode_env;
  logic signed [23:0] const_gain;

  logic [30:0]        sample_idx;
  int                 seg_ptr;
  int                 npts;
  logic [30:0]        bp_time[egps_pkg::MAX_POINTS];
  logic signed [23:0] bp_gain[egps_pkg::MAX_POINTS];
  logic signed [47:0] bp_slope[egps_pkg::MAX_POINTS];
  logic signed [47:0] tail_slope;
  logic signed [23:0] max_val, min_val;
  logic [30:0]        max_at, max_n, min_at, min_n;

  egps_pkg::out_beat_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [47:0] seg_slope_of(logic signed [23:0] g0,
      logic signed [23:0] g1, logic [30:0] t0, logic [30:0] t1);
    longint num, q;
    if (t1 <= t0) return '0;
    num = (longint'(g1) - longint'(g0)) * 64'sd16777216;
    q = num / (longint'({1'b0, t1}) - longint'({1'b0, t0}));
    if (q > 64'sh7fffffffffff) q = 64'sh7fffffffffff;
    if (q < -64'sh800000000000) q = -64'sh800000000000;
    return q[47:0];
  endfunction

  function automatic logic [30:0] seg_start(int k);
    return k == 0 ? 31'd0 : bp_time[k-1];
  endfunction

  function automatic logic signed [23:0] seg_start_gain(int k);
    return k == 0 ? 24'sd0 : bp_gain[k-1];
  endfunction

  function automatic logic [30:0] seg_end(int k);
    return k < npts ? bp_time[k] : egps_pkg::LAST_INDEX;
  endfunction

  function automatic logic signed [47:0] seg_slope(int k);
    return k < npts ? bp_slope[k] : tail_slope;
  endfunction

  function automatic logic signed [23:0] sat24(longint x);
    if (x > 8388607) return 24'sh7fffff;
    if (x < -8388608) return -24'sh800000;
    return x[23:0];
  endfunction

  function automatic void clear_all();
    sample_idx = '0; seg_ptr = 0; npts = 0; tail_slope = '0;
    max_val = '0; max_at = '0; max_n = '0;
    min_val = '0; min_at = '0; min_n = '0;
  endfunction

  function automatic logic signed [23:0] envelope_at(logic [30:0] i);
    logic signed [95:0] sl, span, prod;
    if (seg_ptr > npts || i < seg_start(seg_ptr)) seg_ptr = 0;
    while (seg_ptr < npts && i > seg_end(seg_ptr)) seg_ptr++;
    sl = seg_slope(seg_ptr);
    span = $signed({65'b0, i - seg_start(seg_ptr)});
    prod = sl * span;
    return sat24(longint'(seg_start_gain(seg_ptr)) + longint'(prod >>> 24));
  endfunction

  function automatic void predict(egps_pkg::in_beat_t b);
    egps_pkg::out_beat_t r;
    logic [30:0] t, t0;
    logic signed [23:0] g, v;
    longint p;
    r = '0;
    case (b.cmd)
      egps_pkg::CMD_LOAD: begin
        if (npts < egps_pkg::MAX_POINTS) begin
          t0 = seg_start(npts);
          t = (b.point_time < t0) ? t0 : b.point_time;
          bp_time[npts] = t;
          bp_gain[npts] = b.point_gain;
          bp_slope[npts] = seg_slope_of(seg_start_gain(npts), b.point_gain, t0, t);
          npts++;
          tail_slope = seg_slope_of(b.point_gain, 24'sd0, t, egps_pkg::LAST_INDEX);
        end
      end
      egps_pkg::CMD_CLEAR: clear_all();
      egps_pkg::CMD_REPORT: begin
        r.kind = 1'b1;
        r.peak_max = max_val[22:0];
        r.max_position = max_at;
        r.max_count = max_n;
        r.peak_min = min_val;
        r.min_position = min_at;
        r.min_count = min_n;
        expected_q.push_back(r);
      end
      default: begin
        g = mode_env ? envelope_at(sample_idx) : const_gain;
        p = longint'($signed(b.sample_in)) * longint'(g) + 32768;
        v = sat24(p >>> 16);
        if (v >= max_val && max_n < egps_pkg::LAST_INDEX) max_n++;
        if (v <= min_val && min_n < egps_pkg::LAST_INDEX) min_n++;
        if (v > max_val) begin
          max_val = v; max_at = sample_idx; max_n = 31'd1;
        end
        if (v < min_val) begin
          min_val = v; min_at = sample_idx; min_n = 31'd1;
        end
        if (sample_idx < egps_pkg::LAST_INDEX) sample_idx++;
        r.scaled_sample = v;
        expected_q.push_back(r);
      end
    endcase
  endfunction

  function automatic void unpack_fields(egps_pkg::out_beat_t x,
                                        output longint unsigned f[8]);
    f[0] = x.kind;          f[1] = x.scaled_sample; f[2] = x.peak_max;
    f[3] = x.max_position;  f[4] = x.max_count;     f[5] = x.peak_min;
    f[6] = x.min_position;  f[7] = x.min_count;
  endfunction

  string field_name[8] = '{"kind", "scaled_sample", "peak_max", "max_position",
                           "max_count", "peak_min", "min_position", "min_count"};

  always @(posedge clk) begin
    longint unsigned fe[8], fa[8];
    egps_pkg::out_beat_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      mode_env = 1'b0;
      const_gain = 24'sd65536;
      clear_all();
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == egps_pkg::CFG_GAIN_MODE) mode_env = cfg_wdata[0];
        else const_gain = cfg_wdata;
      end
      // result beat is checked before the input beat of the same edge is predicted
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   out_data);
          errs = errs + 1;
        end else begin
          want = expected_q.pop_front();
          unpack_fields(want, fe);
          unpack_fields(out_data, fa);
          for (int k = 0; k < 8; k++)
            if (fe[k] != fa[k]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time,
                       field_name[k], fe[k], fa[k]);
              errs = errs + 1;
            end
        end
      end
      if (in_valid && in_ready) predict(in_data);
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: verif/tb_top.sv
// tb_top: stimulus and verdict for envelope_gain_with_peak_stats; results are
// checked by egps_checker. Depends on egps_pkg and egps_stream_if.
`timescale 1ns / 1ps
module tb_top;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  int          fails, pending, results_seen;
  int          tx_idle = 0, rx_idle = 0;
  int          beats_sent = 0;
  int          cycles = 0;

  egps_stream_if #(.T(egps_pkg::in_beat_t))  in_if (clk);
  egps_stream_if #(.T(egps_pkg::out_beat_t)) out_if (clk);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  envelope_gain_with_peak_stats i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  egps_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fails), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_if.ready <= rst_n && ($urandom_range(99) >= rx_idle);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[envelope_gain_with_peak_stats] ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [15:0] smp, logic [30:0] t,
                      logic [23:0] g);
    egps_pkg::in_beat_t b;
    b.cmd = cmd; b.sample_in = smp; b.point_time = t; b.point_gain = g;
    while ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // loads give no result, so let any slope division finish
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic sample(logic [15:0] s);
    send(egps_pkg::CMD_SAMPLE, s, 31'($urandom), 24'($urandom));
  endtask

  // restart, a run of breakpoints, then samples with the odd report and a closing report
  task automatic envelope_run();
    int n, m;
    logic [30:0] t;
    logic [23:0] g;
    send(egps_pkg::CMD_CLEAR, 16'($urandom), 31'($urandom), 24'($urandom));
    n = $urandom_range(0, egps_pkg::MAX_POINTS + 1);
    t = '0;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: t = 31'(t - $urandom_range(1, 10));
        1: ;
        default: t = 31'(t + $urandom_range(1, 12));
      endcase
      g = ($urandom_range(3) == 0) ? 24'($urandom) :
          24'($signed($urandom_range(0, 262144)) - 131072);
      send(egps_pkg::CMD_LOAD, 16'($urandom), t, g);
    end
    m = $urandom_range(8, 30);
    for (int k = 0; k < m; k++) begin
      if ($urandom_range(9) == 0)
        send(egps_pkg::CMD_REPORT, 16'($urandom), 31'($urandom), 24'($urandom));
      else sample(16'($urandom));
    end
    send(egps_pkg::CMD_REPORT, 16'($urandom), 31'($urandom), 24'($urandom));
  endtask

  initial begin
    int phase_end;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // constant gain at reset, full-scale samples
    sample(16'h7fff); sample(16'h8000); sample(16'h0000); sample(16'h0001);
    send(egps_pkg::CMD_REPORT, '0, '0, '0);
    wait_idle();
    write_reg(egps_pkg::CFG_CONST_GAIN, 24'h7fffff);
    sample(16'h7fff); sample(16'h8000); sample(16'h8000);
    send(egps_pkg::CMD_REPORT, '0, '0, '0);
    wait_idle();
    write_reg(egps_pkg::CFG_CONST_GAIN, 24'h800000);
    sample(16'h7fff); sample(16'h8000);
    wait_idle();
    write_reg(egps_pkg::CFG_GAIN_MODE, 24'd1);
    // empty envelope gives zero gain
    sample(16'h4000);
    // a step at equal indices, a decreasing index, and loads past a full store
    send(egps_pkg::CMD_LOAD, '0, 31'd2, 24'h7fffff);
    send(egps_pkg::CMD_LOAD, '0, 31'd2, 24'h800000);
    send(egps_pkg::CMD_LOAD, '0, 31'd1, 24'h010000);
    for (int k = 0; k < 14; k++)
      send(egps_pkg::CMD_LOAD, '0, 31'd3 + 31'(k), 24'(k * 9000));
    send(egps_pkg::CMD_LOAD, '0, 31'h7ffffffe, 24'h7fffff);
    for (int k = 0; k < 5; k++) sample(16'($urandom));
    send(egps_pkg::CMD_REPORT, '0, '0, '0);
    send(egps_pkg::CMD_CLEAR, '0, '0, '0);
    send(egps_pkg::CMD_LOAD, '0, 31'h7ffffffe, 24'h7fffff);
    sample(16'h7fff);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 32 : (phase == 1) ? 60 : 0;
      rx_idle = (phase == 0) ? 60 : (phase == 1) ? 32 : 0;
      write_reg(egps_pkg::CFG_GAIN_MODE, 24'(phase != 1));
      write_reg(egps_pkg::CFG_CONST_GAIN, (phase == 1) ? 24'($urandom) : 24'h010000);
      phase_end = beats_sent + 170;
      while (beats_sent < phase_end) begin
        if ($urandom_range(7) == 0)
          send(2'($urandom), 16'($urandom), 31'($urandom), 24'($urandom));
        else envelope_run();
      end
      wait_idle();
    end

    $display("%0d input beats, %0d result beats checked over constant and envelope gain",
             beats_sent, results_seen);
    if (fails == 0) begin
      $display("[envelope_gain_with_peak_stats] OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("[envelope_gain_with_peak_stats] ERROR");
    end
    $finish;
  end
endmodule
